// File: rtl/lsno_pkg.sv
package lsno_pkg;

	// scan geometry
	localparam int MAX_PINGS = 2048;
	localparam int PING_W    = $clog2(MAX_PINGS);

	// field widths
	localparam int RANGE_W = 16;
	localparam int SUM_W   = RANGE_W + 4;
	localparam int CFG_W   = RANGE_W;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_DIST_FLOOR   = 2'd0,
		REG_DIST_CEIL    = 2'd1,
		REG_WINDOW_START = 2'd2,
		REG_WINDOW_END   = 2'd3
	} cfg_reg_t;

	// settings the tracker needs
	typedef struct packed {
		logic [RANGE_W-1:0] dist_ceil;
		logic [PING_W-1:0]  window_start;
		logic [PING_W-1:0]  window_end;
	} track_cfg_t;

	// one clamped ping held in the input register
	typedef struct packed {
		logic               valid;
		logic [RANGE_W-1:0] sample;
		logic               clamped;
		logic               last;
	} ping_t;

endpackage

// File: rtl/lsno_tracker.sv
module lsno_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  lsno_pkg::ping_t              ping,
	input  lsno_pkg::track_cfg_t         cfg,
	output logic [lsno_pkg::RANGE_W-1:0] nearest
);
	import lsno_pkg::*;

	logic [RANGE_W-1:0] tap_q [4];
	logic [1:0]         flag_q;
	logic [PING_W-1:0]  index_q;
	logic [RANGE_W-1:0] min_q;
	logic               min_valid_q;

	logic [SUM_W-1:0]   sum;
	logic [RANGE_W-1:0] smooth;
	logic [PING_W-1:0]  centre;
	logic               qualify;

	// 1-4-6-4-1 binomial sum over the current ping and four earlier ones
	always_comb begin
		sum = SUM_W'(tap_q[3])
			+ (SUM_W'(tap_q[2]) << 2)
			+ (SUM_W'(tap_q[1]) << 2) + (SUM_W'(tap_q[1]) << 1)
			+ (SUM_W'(tap_q[0]) << 2)
			+ SUM_W'(ping.sample);
		smooth = sum[SUM_W-1:4];
		centre = index_q - PING_W'(2);
	end

	// smoothed centre two pings back qualifies for the minimum
	always_comb begin
		qualify = (index_q >= PING_W'(2)) && !flag_q[1]
			&& (centre >= cfg.window_start) && (centre < cfg.window_end)
			&& (smooth < cfg.dist_ceil)
			&& (!min_valid_q || smooth < min_q);
		if (qualify) begin
			nearest = smooth;
		end else if (min_valid_q) begin
			nearest = min_q;
		end else begin
			nearest = cfg.dist_ceil;
		end
	end

	// scan state, cleared after the last ping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				tap_q[k] <= '0;
			end
			flag_q      <= '0;
			index_q     <= '0;
			min_q       <= '0;
			min_valid_q <= 1'b0;
		end else if (step) begin
			if (ping.last) begin
				for (int k = 0; k < 4; k++) begin
					tap_q[k] <= '0;
				end
				flag_q      <= '0;
				index_q     <= '0;
				min_q       <= '0;
				min_valid_q <= 1'b0;
			end else begin
				tap_q[3] <= tap_q[2];
				tap_q[2] <= tap_q[1];
				tap_q[1] <= tap_q[0];
				tap_q[0] <= ping.sample;
				flag_q   <= {flag_q[0], ping.clamped};
				if (index_q != PING_W'(MAX_PINGS - 1)) begin
					index_q <= index_q + PING_W'(1);
				end
				if (qualify) begin
					min_q       <= smooth;
					min_valid_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/lidar_scan_nearest_obstacle_core.sv
// Nearest-obstacle finder for a lidar scan. Range samples (mm) stream in one
// beat per clock; each is clamped to the configured floor and ceiling, smoothed
// by a 1-4-6-4-1 binomial filter (sum divided by 16, truncated), and the least
// smoothed value of an unclamped ping whose index lies in
// window_start..window_end-1 is tracked. On the beat marked last_of_scan one
// result beat carries that minimum, or the ceiling when no ping qualified, and
// the scan state clears. Each ping is clamped into the input register, then
// smoothed and compared in the tracker; a new beat is taken every clock, and
// input stall rises only while a last ping waits behind an untaken result.
// Write the configuration registers only while the block is idle.
module lidar_scan_nearest_obstacle_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [lsno_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lsno_pkg::RANGE_W-1:0] range_sample,
	input  logic                         last_of_scan,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lsno_pkg::RANGE_W-1:0] nearest_distance
);
	import lsno_pkg::*;

	logic [RANGE_W-1:0] dist_floor_q;
	logic [RANGE_W-1:0] dist_ceil_q;
	logic [PING_W-1:0]  window_start_q;
	logic [PING_W-1:0]  window_end_q;

	ping_t              ping_s1;
	logic               step;
	logic               in_take;
	logic [RANGE_W-1:0] clamp_val;
	logic               clamp_hit;
	track_cfg_t         track_cfg;
	logic [RANGE_W-1:0] nearest;
	logic               out_valid_q;
	logic [RANGE_W-1:0] result_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_floor_q   <= '0;
			dist_ceil_q    <= '1;
			window_start_q <= PING_W'(2);
			window_end_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DIST_FLOOR:   dist_floor_q   <= cfg_data[RANGE_W-1:0];
				REG_DIST_CEIL:    dist_ceil_q    <= cfg_data[RANGE_W-1:0];
				REG_WINDOW_START: window_start_q <= cfg_data[PING_W-1:0];
				REG_WINDOW_END:   window_end_q   <= cfg_data[PING_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the incoming sample
	always_comb begin
		priority if (range_sample <= dist_floor_q) begin
			clamp_val = dist_floor_q;
			clamp_hit = 1'b1;
		end else if (range_sample >= dist_ceil_q) begin
			clamp_val = dist_ceil_q;
			clamp_hit = 1'b1;
		end else begin
			clamp_val = range_sample;
			clamp_hit = 1'b0;
		end
	end

	// stage 1 moves on unless a last ping waits behind an untaken result
	assign step     = ping_s1.valid && !(ping_s1.last && out_valid_q && out_stall);
	assign in_stall = ping_s1.valid && !step;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_s1 <= '0;
		end else if (in_take) begin
			ping_s1.valid   <= 1'b1;
			ping_s1.sample  <= clamp_val;
			ping_s1.clamped <= clamp_hit;
			ping_s1.last    <= last_of_scan;
		end else if (step) begin
			ping_s1.valid <= 1'b0;
		end
	end

	assign track_cfg.dist_ceil    = dist_ceil_q;
	assign track_cfg.window_start = window_start_q;
	assign track_cfg.window_end   = window_end_q;

	// smoothing and window minimum
	lsno_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.ping    (ping_s1),
		.cfg     (track_cfg),
		.nearest (nearest)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && ping_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && ping_s1.last) begin
			result_q <= nearest;
		end
	end

	assign out_valid        = out_valid_q;
	assign nearest_distance = result_q;

endmodule

// File: dv/lidar_scan_nearest_obstacle_core_tb.sv
module lidar_scan_nearest_obstacle_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsno_pkg::*;

	localparam int PERIOD       = 10;
	localparam int DRAIN_CYC    = 6;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_PINGS = 1300;

	// directed plan: register writes and pings, some with a hand-typed result
	typedef enum bit { ROW_PING, ROW_REG } row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		cfg_reg_t           which;
		logic [RANGE_W-1:0] value;
		logic               last;
		bit                 typed;
		logic [RANGE_W-1:0] want;
	} plan_row_t;

	localparam int PLAN_LEN = 34;

	plan_row_t plan [PLAN_LEN] = '{
		// defaults: window empty, so a one-ping scan reports the ceiling
		'{ROW_PING, REG_DIST_FLOOR,   16'd0,     1'b1, 1'b1, 16'd65535},
		'{ROW_PING, REG_DIST_FLOOR,   16'd65535, 1'b1, 1'b1, 16'd65535},
		// ordinary window, pings clamped at both ends mixed in
		'{ROW_REG,  REG_DIST_FLOOR,   16'd100,   1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_DIST_CEIL,    16'd60000, 1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_WINDOW_START, 16'd2,     1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_WINDOW_END,   16'd9,     1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd5000,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd100,   1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd65535, 1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd3000,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd3200,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd2800,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd0,     1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd4000,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd4100,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd4200,  1'b1, 1'b0, 16'd0},
		// window from zero to the top: pre-scan taps read zero, tail centers never formed
		'{ROW_REG,  REG_WINDOW_START, 16'd0,     1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_WINDOW_END,   16'd2047,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd1000,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd1200,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd900,   1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd1500,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd1100,  1'b1, 1'b0, 16'd0},
		// crossed limits: every ping clamped
		'{ROW_REG,  REG_DIST_FLOOR,   16'd5000,  1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_DIST_CEIL,    16'd1000,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd3000,  1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd500,   1'b1, 1'b1, 16'd1000},
		// reversed window: nothing qualifies
		'{ROW_REG,  REG_DIST_FLOOR,   16'd0,     1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_DIST_CEIL,    16'd65535, 1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_WINDOW_START, 16'd5,     1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_WINDOW_END,   16'd3,     1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd10,    1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd20,    1'b0, 1'b0, 16'd0},
		'{ROW_PING, REG_DIST_FLOOR,   16'd30,    1'b1, 1'b1, 16'd65535}
	};

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	cfg_reg_t           cfg_index    = REG_DIST_FLOOR;
	logic [CFG_W-1:0]   cfg_data     = '0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [RANGE_W-1:0] range_sample = '0;
	logic               last_of_scan = 1'b0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [RANGE_W-1:0] nearest_distance;

	lidar_scan_nearest_obstacle_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.range_sample     (range_sample),
		.last_of_scan     (last_of_scan),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.nearest_distance (nearest_distance)
	);

	always #(PERIOD / 2) clk = ~clk;

	// shadow settings
	logic [RANGE_W-1:0] lim_lo = '0;
	logic [RANGE_W-1:0] lim_hi = '1;
	logic [PING_W-1:0]  win_lo = PING_W'(2);
	logic [PING_W-1:0]  win_hi = '0;

	// shadow scan state
	logic [RANGE_W-1:0] tap_hist [4];
	logic               clamp_hist [2];
	logic [PING_W-1:0]  ping_pos;
	logic [RANGE_W-1:0] lowest_seen;
	bit                 lowest_ok;

	logic [RANGE_W-1:0] nearest_q [$];

	bit steady  = 1'b0;
	bit settled = 1'b1;
	int errors;
	int checked;
	int pings;
	int scans;
	int writes;
	int idle_cycles;
	logic [RANGE_W-1:0] due;

	task automatic clear_scan();
		for (int k = 0; k < 4; k++) tap_hist[k] = '0;
		clamp_hist[0] = 1'b0;
		clamp_hist[1] = 1'b0;
		ping_pos      = '0;
		lowest_seen   = '0;
		lowest_ok     = 1'b0;
	endtask

	// clamp, smooth the center two pings back, track the window minimum
	task automatic track_ping(input logic [RANGE_W-1:0] mm, input logic last,
				  output bit emits, output logic [RANGE_W-1:0] nearest);
		logic [RANGE_W-1:0] kept;
		logic               hit;
		logic [SUM_W-1:0]   acc;
		logic [RANGE_W-1:0] smooth;
		logic [PING_W-1:0]  center;
		if (mm <= lim_lo) begin
			kept = lim_lo;
			hit  = 1'b1;
		end else if (mm >= lim_hi) begin
			kept = lim_hi;
			hit  = 1'b1;
		end else begin
			kept = mm;
			hit  = 1'b0;
		end
		if (ping_pos >= PING_W'(2)) begin
			center = ping_pos - PING_W'(2);
			acc = SUM_W'(tap_hist[3]) + (SUM_W'(tap_hist[2]) << 2)
			    + (SUM_W'(tap_hist[1]) << 2) + (SUM_W'(tap_hist[1]) << 1)
			    + (SUM_W'(tap_hist[0]) << 2) + SUM_W'(kept);
			smooth = acc[SUM_W-1:4];
			if (!clamp_hist[1] && center >= win_lo && center < win_hi && smooth < lim_hi
			    && (!lowest_ok || smooth < lowest_seen)) begin
				lowest_seen = smooth;
				lowest_ok   = 1'b1;
			end
		end
		tap_hist[3]   = tap_hist[2];
		tap_hist[2]   = tap_hist[1];
		tap_hist[1]   = tap_hist[0];
		tap_hist[0]   = kept;
		clamp_hist[1] = clamp_hist[0];
		clamp_hist[0] = hit;
		if (ping_pos != PING_W'(MAX_PINGS - 1)) ping_pos++;
		emits   = last;
		nearest = lowest_ok ? lowest_seen : lim_hi;
		if (last) clear_scan();
	endtask

	// drop valid, wait for every result and let the pipeline empty
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		cfg_we   = 1'b0;
		while (nearest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		settled = 1'b1;
	endtask

	task automatic write_setting(input cfg_reg_t which, input logic [CFG_W-1:0] value);
		if (!settled) settle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = which;
		cfg_data  = value;
		@(posedge clk);
		case (which)
			REG_DIST_FLOOR:   lim_lo = value;
			REG_DIST_CEIL:    lim_hi = value;
			REG_WINDOW_START: win_lo = value[PING_W-1:0];
			REG_WINDOW_END:   win_hi = value[PING_W-1:0];
		endcase
		writes++;
	endtask

	// one input beat with random gaps ahead of it
	task automatic send_ping(input logic [RANGE_W-1:0] mm, input logic last,
				 input bit typed, input logic [RANGE_W-1:0] want);
		bit                 emits;
		logic [RANGE_W-1:0] nearest;
		@(negedge clk);
		cfg_we = 1'b0;
		if (!steady && $urandom_range(99) < 31) begin
			in_valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 31);
		end
		in_valid     = 1'b1;
		range_sample = mm;
		last_of_scan = last;
		do @(posedge clk); while (in_stall);
		track_ping(mm, last, emits, nearest);
		if (emits) nearest_q.push_back(typed ? want : nearest);
		settled = 1'b0;
		pings++;
		if (last) scans++;
	endtask

	function automatic logic [RANGE_W-1:0] pick_range();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			2:       return lim_lo;
			3:       return lim_hi;
			4, 5:    return RANGE_W'($urandom);
			default: return (lim_lo < lim_hi) ? RANGE_W'($urandom_range(lim_hi, lim_lo))
							  : RANGE_W'($urandom);
		endcase
	endfunction

	// receiver stalls at random
	always @(negedge clk) out_stall <= !steady && ($urandom_range(99) < 31);

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (nearest_q.size() == 0) begin
				errors++;
				$display("%0t: nearest_distance expected none, got %0d", $time,
					 nearest_distance);
			end else begin
				due = nearest_q.pop_front();
				checked++;
				if (nearest_distance !== due) begin
					errors++;
					$display("%0t: nearest_distance expected %0d, got %0d", $time, due,
						 nearest_distance);
				end
			end
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int                 phase;
		int                 n_scans;
		int                 len;
		logic [RANGE_W-1:0] lo;
		logic [RANGE_W-1:0] hi;
		logic [PING_W-1:0]  ws;
		logic [PING_W-1:0]  we;
		clear_scan();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed plan
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				write_setting(plan[i].which, plan[i].value);
			else
				send_ping(plan[i].value, plan[i].last, plan[i].typed, plan[i].want);
		end

		// random settings, each followed by a few whole scans
		phase = 0;
		while (pings < RANDOM_PINGS) begin
			case ($urandom_range(7))
				0:       lo = '0;
				1:       lo = '1;
				2:       lo = RANGE_W'($urandom);
				default: lo = RANGE_W'($urandom_range(2000));
			endcase
			case ($urandom_range(7))
				0:       hi = '1;
				1:       hi = '0;
				2:       hi = RANGE_W'($urandom);
				default: hi = RANGE_W'($urandom_range(65535, 20000));
			endcase
			case ($urandom_range(7))
				0:       ws = '1;
				1:       ws = PING_W'($urandom_range(1));
				default: ws = PING_W'($urandom_range(24));
			endcase
			case ($urandom_range(7))
				0:       we = '1;
				1:       we = '0;
				default: we = PING_W'($urandom_range(40));
			endcase
			if (phase == 0 || $urandom_range(3) != 0) write_setting(REG_DIST_FLOOR, lo);
			if (phase == 0 || $urandom_range(3) != 0) write_setting(REG_DIST_CEIL, hi);
			if (phase == 0 || $urandom_range(3) != 0)
				write_setting(REG_WINDOW_START, CFG_W'(ws));
			if (phase == 0 || $urandom_range(3) != 0)
				write_setting(REG_WINDOW_END, CFG_W'(we));
			// a stretch of phases runs with no gaps on either side
			steady  = (phase >= 4 && phase < 7);
			n_scans = $urandom_range(6, 1);
			for (int s = 0; s < n_scans; s++) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(120, 41)
							       : $urandom_range(40, 1);
				for (int p = 0; p < len; p++)
					send_ping(pick_range(), p == len - 1, 1'b0, '0);
			end
			phase++;
		end
		steady = 1'b0;

		settle();
		$display("covered %0d pings in %0d scans, %0d register writes, %0d random settings",
			 pings, scans, writes, phase);
		$display("%0d results checked, %0d mismatches", checked, errors);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: lidar_scan_nearest_obstacle_core.f
rtl/lsno_pkg.sv
rtl/lsno_tracker.sv
rtl/lidar_scan_nearest_obstacle_core.sv
dv/lidar_scan_nearest_obstacle_core_tb.sv
